// ===== rtl/core/linear_probe_hash_find_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash find core
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_FIND_CORE_DEFINES_SVH
`define LINEAR_PROBE_HASH_FIND_CORE_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define LPHF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define LPHF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== rtl/core/lphf_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear probe hash find package
// Sizes, codes, state type and the bundles passed to the remainder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lphf_pkg;

  // Table geometry and field widths.
  localparam int TABLE_DEPTH = 1024;
  localparam int POS_W       = 10;
  localparam int SIZE_W      = 11;
  localparam int KEY_W       = 31;
  localparam int SLOT_ST_W   = 2;
  localparam int OUTCOME_W   = 2;
  localparam int ENTRY_W     = SLOT_ST_W + KEY_W;
  localparam int DIV_CNT_W   = $clog2(KEY_W);

  // Command codes.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_FIND  = 1'b1;

  // Slot state codes.
  localparam logic [SLOT_ST_W-1:0] SLOT_VALID   = 2'd0;
  localparam logic [SLOT_ST_W-1:0] SLOT_EMPTY   = 2'd1;
  localparam logic [SLOT_ST_W-1:0] SLOT_DELETED = 2'd2;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OUT_FOUND = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_FREE  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_FULL  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_DONE
  } state_e;

  // Request to the remainder unit.
  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } mod_req_t;

  // Answer from the remainder unit.
  typedef struct packed {
    logic             done;
    logic [POS_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/linear_probe_hash_find_core.sv =====
// A write beat is stored in the cycle it is accepted and gives no result.
// A find runs the bit-serial key modulo, then one slot read per cycle from the table RAM
// over the probe, then the result register.
// One item at a time; a find that ends while a result still waits is held, blocking input.
// Reset: table size goes to 1024 and a clearing pass marks every slot empty; no input
// beat is accepted until it ends, configuration writes are taken.
// ----------------------------------------------------------------------------
// Linear probe hash find core
// Open-addressed hash table with a linear probing lookup over one slot RAM.
// ----------------------------------------------------------------------------
`default_nettype none

`include "linear_probe_hash_find_core_defines.svh"

module linear_probe_hash_find_core
  import lphf_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration
  input  wire logic                 cfg_we_i,
  input  wire logic [SIZE_W-1:0]    cfg_wdata_i,
  // Input channel
  input  wire logic                 in_valid_i,
  output      logic                 in_ready_o,
  input  wire logic                 cmd_i,
  input  wire logic [KEY_W-1:0]     key_i,
  input  wire logic [POS_W-1:0]     slot_i,
  input  wire logic [SLOT_ST_W-1:0] slot_state_i,
  // Output channel
  output      logic                 out_valid_o,
  input  wire logic                 out_ready_i,
  output      logic [OUTCOME_W-1:0] outcome_o,
  output      logic [POS_W-1:0]     position_o
);

  state_e               state_q, state_d;
  logic [SIZE_W-1:0]    tsize_q;
  logic [POS_W-1:0]     clr_q;
  logic [KEY_W-1:0]     key_q;
  logic [SIZE_W-1:0]    n_q;
  logic [SIZE_W-1:0]    n_use;
  logic [POS_W-1:0]     pos_q;
  logic [SIZE_W-1:0]    issued_q;
  logic [POS_W-1:0]     rd_pos_q;
  logic                 rd_vld_q;
  logic                 found_q;
  logic [POS_W-1:0]     found_pos_q;
  logic                 have_free_q;
  logic [POS_W-1:0]     free_pos_q;
  logic                 out_valid_q;
  logic [OUTCOME_W-1:0] outcome_q;
  logic [POS_W-1:0]     position_q;

  logic                 in_beat;
  logic                 issue;
  logic                 eval;
  logic                 hit;
  logic                 out_free;
  logic [SIZE_W-1:0]    pos_inc;
  logic [POS_W-1:0]     pos_nxt;

  logic                 mem_we;
  logic [POS_W-1:0]     mem_waddr;
  logic [ENTRY_W-1:0]   mem_wdata;
  logic                 mem_re;
  logic [ENTRY_W-1:0]   mem_rdata;
  logic [SLOT_ST_W-1:0] ent_state;
  logic [KEY_W-1:0]     ent_key;

  mod_req_t             mod_req;
  mod_rsp_t             mod_rsp;

  // Slot table: state and key of each slot in one entry.
  lphf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (pos_q),
    .rdata_o (mem_rdata)
  );

  // Hash of the key.
  lphf_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Table size in use, clamped to one and to the table depth.
  always_comb begin
    if (tsize_q == '0) begin
      n_use = SIZE_W'(1);
    end else if (tsize_q > SIZE_W'(TABLE_DEPTH)) begin
      n_use = SIZE_W'(TABLE_DEPTH);
    end else begin
      n_use = tsize_q;
    end
  end

  // Probe bookkeeping.
  assign ent_state = mem_rdata[ENTRY_W-1 -: SLOT_ST_W];
  assign ent_key   = mem_rdata[KEY_W-1:0];
  assign issue     = (issued_q != n_q);
  assign eval      = (state_q == S_PROBE) && rd_vld_q;
  assign hit       = eval && (ent_state == SLOT_VALID) && (ent_key == key_q);
  assign pos_inc   = {1'b0, pos_q} + SIZE_W'(1);
  assign pos_nxt   = (pos_inc >= n_q) ? '0 : pos_inc[POS_W-1:0];
  assign out_free  = !out_valid_q || out_ready_i;
  assign in_beat   = in_valid_i && in_ready_o;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == POS_W'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i && (cmd_i == CMD_FIND)) begin
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (mod_rsp.done) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (hit || (!issue && !rd_vld_q)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Handshake, memory and hash unit controls.
  always_comb begin
    in_ready_o       = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = slot_i;
    mem_wdata        = {slot_state_i, key_i};
    mem_re           = 1'b0;
    mod_req.start    = 1'b0;
    mod_req.dividend = key_i;
    mod_req.divisor  = n_use;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {SLOT_EMPTY, {KEY_W{1'b0}}};
      end
      S_IDLE: begin
        in_ready_o    = 1'b1;
        mem_we        = in_valid_i && (cmd_i == CMD_WRITE);
        mod_req.start = in_valid_i && (cmd_i == CMD_FIND);
      end
      S_PROBE: begin
        mem_re = issue;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      tsize_q     <= SIZE_W'(TABLE_DEPTH);
      clr_q       <= '0;
      issued_q    <= '0;
      rd_vld_q    <= 1'b0;
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        tsize_q <= cfg_wdata_i;
      end
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      rd_vld_q <= (state_q == S_PROBE) && issue;
      if (state_q == S_HASH) begin
        issued_q    <= '0;
        found_q     <= 1'b0;
        have_free_q <= 1'b0;
      end else if (state_q == S_PROBE) begin
        if (issue) begin
          issued_q <= issued_q + 1'b1;
        end
        if (hit) begin
          found_q <= 1'b1;
        end else if (eval && (ent_state != SLOT_VALID)) begin
          have_free_q <= 1'b1;
        end
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_beat && (cmd_i == CMD_FIND)) begin
      key_q <= key_i;
      n_q   <= n_use;
    end
    if ((state_q == S_HASH) && mod_rsp.done) begin
      pos_q <= mod_rsp.rem;
    end else if ((state_q == S_PROBE) && issue) begin
      pos_q <= pos_nxt;
    end
    rd_pos_q <= pos_q;
    if (hit) begin
      found_pos_q <= rd_pos_q;
    end
    if (eval && (ent_state != SLOT_VALID) && !have_free_q) begin
      free_pos_q <= rd_pos_q;
    end
    if ((state_q == S_DONE) && out_free) begin
      if (found_q) begin
        outcome_q  <= OUT_FOUND;
        position_q <= found_pos_q;
      end else if (have_free_q) begin
        outcome_q  <= OUT_FREE;
        position_q <= free_pos_q;
      end else begin
        outcome_q  <= OUT_FULL;
        position_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign outcome_o   = outcome_q;
  assign position_o  = position_q;

  // Checks.
  `LPHF_ASSERT(a_find_starts_hash,
    (in_valid_i && in_ready_o && (cmd_i == CMD_FIND)) |=> (state_q == S_HASH),
    "accepted find did not start the hash")
  `LPHF_ASSERT_NEVER(a_no_rw_clash, mem_we && mem_re,
    "table written and read in the same cycle")
  `LPHF_ASSERT(a_probe_bounded, (state_q == S_PROBE) |-> (issued_q <= n_q),
    "probe read more slots than the table size")
  `LPHF_ASSERT(a_full_pos_zero,
    (out_valid_o && (outcome_o == OUT_FULL)) |-> (position_o == '0),
    "full result with a non-zero position")

endmodule

`default_nettype wire

// ===== rtl/core/lphf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lphf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lphf_mod.sv =====
// ----------------------------------------------------------------------------
// Remainder unit
// Restoring key modulo table size, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lphf_mod
  import lphf_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mod_req_t req_i,
  output      mod_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0]     dvd_q, dvd_d;
  logic [SIZE_W-1:0]    div_q, div_d;
  logic [SIZE_W-1:0]    rem_q, rem_d;
  logic [SIZE_W:0]      trial;

  // One shift and conditional subtract per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    div_d  = div_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[KEY_W-1]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = req_i.dividend;
      div_d  = req_i.divisor;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, div_q}) begin
        rem_d = SIZE_W'(trial - {1'b0, div_q});
      end else begin
        rem_d = SIZE_W'(trial);
      end
      dvd_d = {dvd_q[KEY_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(KEY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Operand registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    div_q <= div_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = rem_q[POS_W-1:0];

endmodule

`default_nettype wire
